/* sv/rlebg_pkg.sv */
// shared types and constants for the run-length background decoder
package rlebg_pkg;

  // configuration register indexes
  localparam logic [1:0] REG_IMAGE_WIDTH  = 2'd0;
  localparam logic [1:0] REG_IMAGE_HEIGHT = 2'd1;
  localparam logic [1:0] REG_ROW_STRIDE   = 2'd2;

  localparam logic [11:0] RST_IMAGE_WIDTH  = 12'd320;
  localparam logic [11:0] RST_IMAGE_HEIGHT = 12'd200;
  localparam logic [12:0] RST_ROW_STRIDE   = 13'd320;

  // command class, taken from the two top bits of a command byte
  typedef enum logic [1:0] {
    CLS_FILL    = 2'd0,
    CLS_SPACED  = 2'd1,
    CLS_LITERAL = 2'd2,
    CLS_SKIP    = 2'd3
  } cmd_class_t;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       last_byte;
    cmd_class_t cls;
    logic [5:0] count;
  } queue_item_t;

  typedef struct packed {
    logic [11:0] width;
    logic [11:0] height;
    logic [12:0] stride;
  } dims_t;

  typedef struct packed {
    logic        write_valid;
    logic [22:0] pixel_address;
    logic [7:0]  pixel_value;
    logic        last_of_run;
    logic        frame_done;
  } result_t;

endpackage

/* sv/rlebg_front.sv */
// input side: takes bytes, classifies them and queues them for the executor
module rlebg_front (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  logic [7:0]            in_data_byte,
  input  logic                  in_last_byte,
  output logic                  q_valid,
  output rlebg_pkg::queue_item_t q_item,
  input  logic                  q_pop
);
  import rlebg_pkg::*;

  queue_item_t mem_r [2];
  logic        wr_ptr_r, wr_ptr_nxt;
  logic        rd_ptr_r, rd_ptr_nxt;
  logic [1:0]  count_r, count_nxt;
  logic        push;
  logic        pop;
  queue_item_t new_item;

  always_comb begin
    new_item.data_byte = in_data_byte;
    new_item.last_byte = in_last_byte;
    new_item.count     = in_data_byte[5:0];
    case (in_data_byte[7:6])
      2'b11:   new_item.cls = CLS_SKIP;
      2'b10:   new_item.cls = CLS_LITERAL;
      2'b01:   new_item.cls = CLS_SPACED;
      default: new_item.cls = CLS_FILL;
    endcase
  end

  assign in_ready = (count_r != 2'd2);
  assign q_valid  = (count_r != 2'd0);
  assign q_item   = mem_r[rd_ptr_r];
  assign push     = in_valid && in_ready;
  assign pop      = q_pop && q_valid;

  always_comb begin
    wr_ptr_nxt = push ? ~wr_ptr_r : wr_ptr_r;
    rd_ptr_nxt = pop ? ~rd_ptr_r : rd_ptr_r;
    count_nxt  = count_r + 2'(push) - 2'(pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      count_r  <= 2'd0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= new_item;
    end
  end

endmodule

/* sv/rlebg_back.sv */
// executor: keeps the decode state, expands runs into pixel writes
module rlebg_back (
  input  logic                   clk,
  input  logic                   rst_n,
  input  rlebg_pkg::dims_t       dims,
  input  logic                   q_valid,
  input  rlebg_pkg::queue_item_t q_item,
  output logic                   q_pop,
  output logic                   out_valid,
  input  logic                   out_ready,
  output rlebg_pkg::result_t     out_res
);
  import rlebg_pkg::*;

  typedef enum logic [1:0] {
    S_IDLE,
    S_RUN,
    S_FLUSH
  } state_t;

  state_t      state_r, state_nxt;
  logic [11:0] column_r, column_nxt;
  logic [11:0] row_r, row_nxt;
  logic [6:0]  runs_left_r, runs_left_nxt;
  logic [5:0]  repeat_r, repeat_nxt;
  logic        spaced_r, spaced_nxt;
  logic [5:0]  iter_r, iter_nxt;
  logic        pend_valid_r, pend_valid_nxt;
  logic [22:0] pend_addr_r, pend_addr_nxt;
  logic [7:0]  pend_value_r, pend_value_nxt;
  logic        pend_done_r, pend_done_nxt;
  logic        out_valid_r, out_valid_nxt;
  result_t     out_res_r, out_res_nxt;

  logic        out_space;
  logic        push;
  result_t     push_res;
  logic [12:0] width13;
  logic        frame_over;
  // command path
  logic [12:0] cmd_x;
  logic        cmd_wrap;
  logic [11:0] cmd_row;
  // run path
  logic [12:0] cur_col;
  logic [12:0] next_col;
  logic        emit;
  logic        run_wrap;
  logic [11:0] row_inc;
  logic        pix_done;
  logic [24:0] prod;
  logic [22:0] pix_addr;
  logic        run_end;

  assign out_space  = !out_valid_r || out_ready;
  assign width13    = {1'b0, dims.width};
  assign frame_over = (row_r >= dims.height);

  always_comb begin
    if (q_item.cls == CLS_SKIP) begin
      cmd_x = {1'b0, column_r} + 13'(q_item.count) + 13'd1;
    end else begin
      cmd_x = {1'b0, column_r};
    end
    cmd_wrap = (cmd_x >= width13);
    cmd_row  = row_r + 12'(cmd_wrap);
  end

  // one pixel step of a run
  always_comb begin
    cur_col  = {1'b0, column_r} + 13'(spaced_r);
    emit     = (cur_col < width13);
    next_col = cur_col + 13'd1;
    run_wrap = (next_col >= width13);
    row_inc  = row_r + 12'd1;
    pix_done = run_wrap && (row_inc >= dims.height);
    prod     = 25'(row_r) * 25'(dims.stride);
    pix_addr = prod[22:0] + 23'(cur_col);
    run_end  = (iter_r == repeat_r) || pix_done;
  end

  always_comb begin
    state_nxt      = state_r;
    column_nxt     = column_r;
    row_nxt        = row_r;
    runs_left_nxt  = runs_left_r;
    repeat_nxt     = repeat_r;
    spaced_nxt     = spaced_r;
    iter_nxt       = iter_r;
    pend_valid_nxt = pend_valid_r;
    pend_addr_nxt  = pend_addr_r;
    pend_value_nxt = pend_value_r;
    pend_done_nxt  = pend_done_r;
    q_pop          = 1'b0;
    push           = 1'b0;
    push_res       = '0;

    case (state_r)
      S_IDLE: begin
        if (q_valid) begin
          if (frame_over) begin
            if (out_space) begin
              push                = 1'b1;
              push_res.last_of_run = 1'b1;
              push_res.frame_done  = 1'b1;
              q_pop               = 1'b1;
            end
          end else if (runs_left_r == 7'd0) begin
            if (out_space) begin
              repeat_nxt = 6'd0;
              spaced_nxt = (q_item.cls == CLS_SPACED);
              case (q_item.cls)
                CLS_LITERAL: runs_left_nxt = 7'(q_item.count) + 7'd1;
                CLS_SPACED:  begin
                  runs_left_nxt = 7'd1;
                  repeat_nxt    = q_item.count;
                end
                CLS_FILL: begin
                  runs_left_nxt = 7'd1;
                  repeat_nxt    = q_item.count;
                end
                default: runs_left_nxt = runs_left_r;
              endcase
              column_nxt           = cmd_wrap ? 12'd0 : cmd_x[11:0];
              row_nxt              = cmd_row;
              push                 = 1'b1;
              push_res.last_of_run = 1'b1;
              push_res.frame_done  = (cmd_row >= dims.height);
              q_pop                = 1'b1;
            end
          end else begin
            iter_nxt       = 6'd0;
            pend_valid_nxt = 1'b0;
            state_nxt      = S_RUN;
          end
        end
      end

      S_RUN: begin
        // hold the step while a finished pixel cannot move out
        if (!(emit && pend_valid_r && !out_space)) begin
          if (emit) begin
            if (pend_valid_r) begin
              push                   = 1'b1;
              push_res.write_valid   = 1'b1;
              push_res.pixel_address = pend_addr_r;
              push_res.pixel_value   = pend_value_r;
              push_res.frame_done    = pend_done_r;
            end
            pend_valid_nxt = 1'b1;
            pend_addr_nxt  = pix_addr;
            pend_value_nxt = q_item.data_byte;
            pend_done_nxt  = pix_done;
          end
          if (run_wrap) begin
            column_nxt = 12'd0;
            row_nxt    = row_inc;
          end else begin
            column_nxt = next_col[11:0];
          end
          iter_nxt = iter_r + 6'd1;
          if (run_end) begin
            state_nxt = S_FLUSH;
          end
        end
      end

      S_FLUSH: begin
        if (out_space) begin
          push                 = 1'b1;
          push_res.last_of_run = 1'b1;
          if (pend_valid_r) begin
            push_res.write_valid   = 1'b1;
            push_res.pixel_address = pend_addr_r;
            push_res.pixel_value   = pend_value_r;
            push_res.frame_done    = pend_done_r;
          end else begin
            push_res.frame_done = frame_over;
          end
          runs_left_nxt  = runs_left_r - 7'd1;
          pend_valid_nxt = 1'b0;
          q_pop          = 1'b1;
          state_nxt      = S_IDLE;
        end
      end

      default: state_nxt = S_IDLE;
    endcase

    // the final byte of a stream returns the decode state to reset
    if (q_pop && q_item.last_byte) begin
      column_nxt    = 12'd0;
      row_nxt       = 12'd0;
      runs_left_nxt = 7'd0;
      repeat_nxt    = 6'd0;
      spaced_nxt    = 1'b0;
    end

    if (push) begin
      out_valid_nxt = 1'b1;
      out_res_nxt   = push_res;
    end else begin
      out_valid_nxt = out_valid_r && !out_ready;
      out_res_nxt   = out_res_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_IDLE;
      column_r     <= 12'd0;
      row_r        <= 12'd0;
      runs_left_r  <= 7'd0;
      repeat_r     <= 6'd0;
      spaced_r     <= 1'b0;
      iter_r       <= 6'd0;
      pend_valid_r <= 1'b0;
      out_valid_r  <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      column_r     <= column_nxt;
      row_r        <= row_nxt;
      runs_left_r  <= runs_left_nxt;
      repeat_r     <= repeat_nxt;
      spaced_r     <= spaced_nxt;
      iter_r       <= iter_nxt;
      pend_valid_r <= pend_valid_nxt;
      out_valid_r  <= out_valid_nxt;
    end
    pend_addr_r  <= pend_addr_nxt;
    pend_value_r <= pend_value_nxt;
    pend_done_r  <= pend_done_nxt;
    out_res_r    <= out_res_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_res   = out_res_r;

endmodule

/* sv/rle_background_decoder_core.sv */
// top level of the run-length background decoder
// Input channel (in_valid/in_ready): one body byte of the coded image per item,
// in_last_byte marks the final byte of a stream; after it the decode state
// (column, row, pending run, command) goes back to its reset value.
// Result channel (out_valid/out_ready): pixel writes, address = row * stride
// + column; a byte that paints nothing gives one item with write_valid low.
// out_last_of_run marks the final item caused by each input byte.
// Config port: cfg_write_en with cfg_index 0 width, 1 height, 2 row stride;
// write only while the block is idle. Reset loads 320, 200 and 320.
// Timing: an accepted byte sits in a two-entry queue; a command byte's result
// is registered in the output register, a data byte's pixels pass the pending
// pixel register, then the output register. The executor takes a command byte
// or a byte after the frame end in its idle state; a data byte goes through
// pixel steps (one step per cycle unless a finished pixel cannot move out) and
// a flush step closing the run. The executor's pixel loop sets the throughput.
// A stalled receiver holds the output register; the executor waits and the
// queue keeps taking bytes until both entries are full.
module rle_background_decoder_core #(
  parameter int unsigned MAX_DIMENSION = 2048
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [7:0]  in_data_byte,
  input  logic        in_last_byte,
  output logic        out_valid,
  input  logic        out_ready,
  output logic        out_write_valid,
  output logic [22:0] out_pixel_address,
  output logic [7:0]  out_pixel_value,
  output logic        out_last_of_run,
  output logic        out_frame_done,
  input  logic        cfg_write_en,
  input  logic [1:0]  cfg_index,
  input  logic [12:0] cfg_data
);
  import rlebg_pkg::*;

  localparam int unsigned DIM_CAP = (MAX_DIMENSION > 4095) ? 4095 : MAX_DIMENSION;
  localparam logic [11:0] DIM_CAP_V = 12'(DIM_CAP);

  logic [11:0] width_r, height_r;
  logic [12:0] stride_r;
  dims_t       dims;
  logic        q_valid;
  queue_item_t q_item;
  logic        q_pop;
  result_t     res;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      width_r  <= RST_IMAGE_WIDTH;
      height_r <= RST_IMAGE_HEIGHT;
      stride_r <= RST_ROW_STRIDE;
    end else if (cfg_write_en) begin
      case (cfg_index)
        REG_IMAGE_WIDTH:  width_r  <= cfg_data[11:0];
        REG_IMAGE_HEIGHT: height_r <= cfg_data[11:0];
        REG_ROW_STRIDE:   stride_r <= cfg_data;
        default: ;
      endcase
    end
  end

  // dimensions saturate at the largest supported frame
  always_comb begin
    dims.width  = (width_r > DIM_CAP_V) ? DIM_CAP_V : width_r;
    dims.height = (height_r > DIM_CAP_V) ? DIM_CAP_V : height_r;
    dims.stride = stride_r;
  end

  rlebg_front u_front (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .in_data_byte (in_data_byte),
    .in_last_byte (in_last_byte),
    .q_valid      (q_valid),
    .q_item       (q_item),
    .q_pop        (q_pop)
  );

  rlebg_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .dims      (dims),
    .q_valid   (q_valid),
    .q_item    (q_item),
    .q_pop     (q_pop),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_res   (res)
  );

  assign out_write_valid   = res.write_valid;
  assign out_pixel_address = res.pixel_address;
  assign out_pixel_value   = res.pixel_value;
  assign out_last_of_run   = res.last_of_run;
  assign out_frame_done    = res.frame_done;

endmodule
